// ===== design/slt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the sorted linked-list table.
package slt_pkg;

	localparam int DEF_CAPACITY = 64;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic       valid;
		logic [1:0] status;
	} result_t;

endpackage

// ===== design/slt_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module slt_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/slt_engine.sv =====
`timescale 1ns / 1ps
// List engine: sequencer over the node memories, list pointers and node allocator.
module slt_engine #(
	parameter int CAPACITY = slt_pkg::DEF_CAPACITY
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [1:0]                       start_cmd,
	input  logic signed [31:0]               start_value,
	output logic                             busy,
	output slt_pkg::result_t                 res,
	output logic [$clog2(CAPACITY+1)-1:0]    count,
	input  logic                             take
);

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam logic [PW-1:0] NIL = PW'(CAPACITY);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_POP   = 4'd1;
	localparam logic [3:0] S_WALK  = 4'd2;
	localparam logic [3:0] S_LINK1 = 4'd3;
	localparam logic [3:0] S_LINK2 = 4'd4;
	localparam logic [3:0] S_UNL1  = 4'd5;
	localparam logic [3:0] S_UNL2  = 4'd6;
	localparam logic [3:0] S_CLR   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	// control state
	logic [3:0]    state_q, state_d;
	logic [PW-1:0] first_q, first_d;
	logic [PW-1:0] tail_q, tail_d;
	logic [PW-1:0] free_q, free_d;
	logic [PW-1:0] fresh_q, fresh_d;
	logic [PW-1:0] count_q, count_d;

	// per-operation payload
	logic [1:0]         cmd_q, cmd_d;
	logic signed [31:0] val_q, val_d;
	logic [PW-1:0]      cur_q, cur_d;
	logic [PW-1:0]      prv_q, prv_d;
	logic [PW-1:0]      aft_q, aft_d;
	logic [PW-1:0]      node_q, node_d;
	logic [1:0]         stat_q, stat_d;

	// memory ports
	logic [AW-1:0]      rd_addr;
	logic               vl_we, nx_we, pv_we;
	logic [AW-1:0]      vl_wa, nx_wa, pv_wa;
	logic [31:0]        vl_wd;
	logic [PW-1:0]      nx_wd, pv_wd;
	logic signed [31:0] vl_rd;
	logic [PW-1:0]      nx_rd, pv_rd;

	slt_ram #(.Width(32), .Depth(CAPACITY)) u_value (
		.clk(clk), .we(vl_we), .waddr(vl_wa), .wdata(vl_wd),
		.raddr(rd_addr), .rdata(vl_rd)
	);

	slt_ram #(.Width(PW), .Depth(CAPACITY)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
		.raddr(rd_addr), .rdata(nx_rd)
	);

	slt_ram #(.Width(PW), .Depth(CAPACITY)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
		.raddr(rd_addr), .rdata(pv_rd)
	);

	always_comb begin
		state_d = state_q;
		first_d = first_q;
		tail_d  = tail_q;
		free_d  = free_q;
		fresh_d = fresh_q;
		count_d = count_q;
		cmd_d   = cmd_q;
		val_d   = val_q;
		cur_d   = cur_q;
		prv_d   = prv_q;
		aft_d   = aft_q;
		node_d  = node_q;
		stat_d  = stat_q;
		rd_addr = cur_q[AW-1:0];
		vl_we   = 1'b0;
		vl_wa   = node_q[AW-1:0];
		vl_wd   = val_q;
		nx_we   = 1'b0;
		nx_wa   = node_q[AW-1:0];
		nx_wd   = cur_q;
		pv_we   = 1'b0;
		pv_wa   = node_q[AW-1:0];
		pv_wd   = prv_q;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_d = start_cmd;
					val_d = start_value;
					prv_d = NIL;
					cur_d = first_q;
					unique case (start_cmd) inside
						slt_pkg::CMD_INSERT: begin
							if (free_q != NIL) begin
								// pop the free list: fetch the successor first
								rd_addr = free_q[AW-1:0];
								node_d  = free_q;
								state_d = S_POP;
							end else if (fresh_q != NIL) begin
								node_d  = fresh_q;
								fresh_d = fresh_q + PW'(1);
								rd_addr = first_q[AW-1:0];
								state_d = (first_q != NIL) ? S_WALK : S_LINK1;
							end else begin
								stat_d  = slt_pkg::ST_FULL;
								state_d = S_DONE;
							end
						end
						slt_pkg::CMD_DELETE, slt_pkg::CMD_SEARCH: begin
							rd_addr = first_q[AW-1:0];
							if (first_q != NIL) begin
								state_d = S_WALK;
							end else begin
								stat_d  = slt_pkg::ST_NOTFOUND;
								state_d = S_DONE;
							end
						end
						slt_pkg::CMD_CLEAR: begin
							state_d = S_CLR;
						end
					endcase
				end
			end
			S_POP: begin
				free_d  = nx_rd;
				rd_addr = first_q[AW-1:0];
				state_d = (first_q != NIL) ? S_WALK : S_LINK1;
			end
			S_WALK: begin
				if (cmd_q == slt_pkg::CMD_INSERT) begin
					if (vl_rd < val_q) begin
						prv_d   = cur_q;
						cur_d   = nx_rd;
						rd_addr = nx_rd[AW-1:0];
						if (nx_rd == NIL) begin
							state_d = S_LINK1;
						end
					end else begin
						state_d = S_LINK1;
					end
				end else if (vl_rd == val_q) begin
					if (cmd_q == slt_pkg::CMD_SEARCH) begin
						stat_d  = slt_pkg::ST_OK;
						state_d = S_DONE;
					end else begin
						prv_d   = pv_rd;
						aft_d   = nx_rd;
						state_d = S_UNL1;
					end
				end else if (val_q < vl_rd) begin
					stat_d  = slt_pkg::ST_NOTFOUND;
					state_d = S_DONE;
				end else begin
					cur_d   = nx_rd;
					rd_addr = nx_rd[AW-1:0];
					if (nx_rd == NIL) begin
						stat_d  = slt_pkg::ST_NOTFOUND;
						state_d = S_DONE;
					end
				end
			end
			S_LINK1: begin
				vl_we   = 1'b1;
				nx_we   = 1'b1;
				pv_we   = 1'b1;
				state_d = S_LINK2;
			end
			S_LINK2: begin
				nx_wa = prv_q[AW-1:0];
				nx_wd = node_q;
				pv_wa = cur_q[AW-1:0];
				pv_wd = node_q;
				if (prv_q != NIL) begin
					nx_we = 1'b1;
				end else begin
					first_d = node_q;
				end
				if (cur_q != NIL) begin
					pv_we = 1'b1;
				end else begin
					tail_d = node_q;
				end
				count_d = count_q + PW'(1);
				stat_d  = slt_pkg::ST_OK;
				state_d = S_DONE;
			end
			S_UNL1: begin
				nx_wa = prv_q[AW-1:0];
				nx_wd = aft_q;
				pv_wa = aft_q[AW-1:0];
				pv_wd = prv_q;
				if (prv_q != NIL) begin
					nx_we = 1'b1;
				end else begin
					first_d = aft_q;
				end
				if (aft_q != NIL) begin
					pv_we = 1'b1;
				end else begin
					tail_d = prv_q;
				end
				state_d = S_UNL2;
			end
			S_UNL2: begin
				nx_we  = 1'b1;
				nx_wa  = cur_q[AW-1:0];
				nx_wd  = free_q;
				free_d = cur_q;
				if (count_q != '0) begin
					count_d = count_q - PW'(1);
				end
				stat_d  = slt_pkg::ST_OK;
				state_d = S_DONE;
			end
			S_CLR: begin
				// splice the whole list in front of the free list
				nx_wa = tail_q[AW-1:0];
				nx_wd = free_q;
				if (first_q != NIL && tail_q != NIL) begin
					nx_we  = 1'b1;
					free_d = first_q;
				end
				first_d = NIL;
				tail_d  = NIL;
				count_d = '0;
				stat_d  = slt_pkg::ST_OK;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= NIL;
			tail_q  <= NIL;
			free_q  <= NIL;
			fresh_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
			tail_q  <= tail_d;
			free_q  <= free_d;
			fresh_q <= fresh_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		val_q  <= val_d;
		cur_q  <= cur_d;
		prv_q  <= prv_d;
		aft_q  <= aft_d;
		node_q <= node_d;
		stat_q <= stat_d;
	end

	assign busy       = (state_q != S_IDLE);
	assign res.valid  = (state_q == S_DONE);
	assign res.status = stat_q;
	assign count      = count_q;

endmodule

// ===== design/sorted_linked_list_table_core.sv =====
`timescale 1ns / 1ps
// Top level of the sorted linked-list table: command channel, engine and result register.
//
// The table keeps up to CAPACITY signed 32-bit values in ascending order as a doubly
// linked list held in three node memories (value, next, prev). Each command beat gives
// exactly one result beat with a status (done/found, not found, or store full) and the
// number of entries after the command. Insert keeps duplicates and places the new value
// before the first entry that is not smaller; delete removes the first equal entry.
// Freed nodes are reused through a free list, and unused nodes come from a counter, so
// no clearing pass is needed after reset. The engine handles one command at a time and
// reads one list node per cycle from the node memories. A new command is taken as soon as the
// previous result has moved into the result register, even while that beat waits.
module sorted_linked_list_table_core #(
	parameter int CAPACITY = slt_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic [6:0]         entry_count
);

	localparam int PW = $clog2(CAPACITY + 1);

	logic             busy;
	logic             start;
	logic             take;
	slt_pkg::result_t res;
	logic [PW-1:0]    count;
	logic [PW+6:0]    count_ext;

	logic             rsp_valid_q;
	logic [1:0]       status_q;
	logic [6:0]       entry_count_q;

	// take a command beat only while the engine is idle
	assign cmd_stall = busy;
	assign start     = cmd_valid && !busy;

	// move a finished result into the result register when it is empty or draining
	assign take = res.valid && (!rsp_valid_q || !rsp_stall);

	slt_engine #(.CAPACITY(CAPACITY)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.start_cmd  (command),
		.start_value(value),
		.busy       (busy),
		.res        (res),
		.count      (count),
		.take       (take)
	);

	// entry count reported modulo 128
	assign count_ext = {7'd0, count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// hold the payload while the beat is stalled
	always_ff @(posedge clk) begin
		if (take) begin
			status_q      <= res.status;
			entry_count_q <= count_ext[6:0];
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule

// ===== verif/sorted_linked_list_table_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the sorted linked-list table: random traffic against a predictor.

module sorted_linked_list_table_core_tb;

	localparam int TABLE_CAP    = slt_pkg::DEF_CAPACITY;
	localparam int RANDOM_ITEMS = 1725;  // directed part adds about 25 more
	localparam int QUIET_LIMIT  = 4000;  // cycles with no beat on either channel
	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
	localparam int SETTLE_CYCLES = 150;  // covers the longest list walk
	localparam int MAX_REPORTS  = 10;

	// one command beat as offered on the input channel
	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] operand;
	} table_cmd_t;

	// one answer the table owes, kept with its command for reporting
	typedef struct {
		logic [1:0]         status;
		logic [6:0]         entry_count;
		logic [1:0]         op;
		logic signed [31:0] operand;
	} table_answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	logic [1:0]         command = slt_pkg::CMD_SEARCH;
	logic signed [31:0] value = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [1:0]         status;
	logic [6:0]         entry_count;

	sorted_linked_list_table_core #(
		.CAPACITY(TABLE_CAP)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.command    (command),
		.value      (value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.entry_count(entry_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor: the list itself, kept as an ascending queue of values.
	// Every node is either on the list, on the free list or never used, so
	// the store is full exactly when the list holds TABLE_CAP entries.
	// ------------------------------------------------------------------
	logic signed [31:0] held_values[$];
	table_answer_t      answers_due[$];

	int n_insert = 0, n_delete = 0, n_search = 0, n_clear = 0;
	int n_refused = 0, n_absent = 0, deepest = 0;

	function automatic table_answer_t table_apply(input logic [1:0] op,
			input logic signed [31:0] operand);
		table_answer_t ans;
		int            spot;
		ans.op      = op;
		ans.operand = operand;
		ans.status  = slt_pkg::ST_OK;
		spot        = -1;
		case (op)
			slt_pkg::CMD_INSERT: begin
				n_insert++;
				if (held_values.size() >= TABLE_CAP) begin
					ans.status = slt_pkg::ST_FULL;
					n_refused++;
				end else begin
					// land in front of the first entry that is not smaller
					spot = held_values.size();
					for (int i = 0; i < held_values.size(); i++) begin
						if (held_values[i] >= operand) begin
							spot = i;
							break;
						end
					end
					held_values.insert(spot, operand);
				end
			end
			slt_pkg::CMD_DELETE, slt_pkg::CMD_SEARCH: begin
				if (op == slt_pkg::CMD_DELETE)
					n_delete++;
				else
					n_search++;
				for (int i = 0; i < held_values.size(); i++) begin
					if (held_values[i] == operand) begin
						spot = i;
						break;
					end
				end
				if (spot < 0) begin
					ans.status = slt_pkg::ST_NOTFOUND;
					n_absent++;
				end else if (op == slt_pkg::CMD_DELETE) begin
					held_values.delete(spot);
				end
			end
			default: begin
				n_clear++;
				held_values.delete();
			end
		endcase
		ans.entry_count = 7'(held_values.size());
		if (held_values.size() > deepest)
			deepest = held_values.size();
		return ans;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus store and helpers
	// ------------------------------------------------------------------
	table_cmd_t         pending[$];
	logic signed [31:0] recent_values[$];  // operands of inserts, to make hits likely
	int                 total_items;

	task automatic queue_op(input logic [1:0] op, input logic signed [31:0] operand);
		table_cmd_t c;
		c.op      = op;
		c.operand = operand;
		pending.push_back(c);
		if (op == slt_pkg::CMD_INSERT) begin
			recent_values.push_back(operand);
			if (recent_values.size() > 96)
				void'(recent_values.pop_front());
		end
	endtask

	function automatic logic signed [31:0] pick_operand();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45 && recent_values.size() > 0)
			return recent_values[$urandom_range(0, recent_values.size() - 1)];
		if (r < 70)
			return int'($urandom_range(0, 16)) - 8;
		if (r < 80) begin
			case ($urandom_range(0, 5))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh8000_0001;
				3: return 32'sh7fff_fffe;
				4: return -1;
				default: return 0;
			endcase
		end
		return $urandom;
	endfunction

	// wait before the next beat, drawn at random, with runs of back-to-back beats
	function automatic int draw_wait(inout int burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst_left = $urandom_range(10, 50);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	// ------------------------------------------------------------------
	// Monitor: sample both channels at the rising edge. Predict first, so
	// the expectation for an accepted command is queued before any answer
	// of the same edge is popped.
	// ------------------------------------------------------------------
	bit cmd_took = 1'b0;
	bit rsp_took = 1'b0;
	bit timed_out = 1'b0;
	int rsp_count = 0;
	int mismatches = 0;
	int quiet = 0;

	task automatic log_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] MISMATCH %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		table_answer_t want;
		if (arst_n) begin
			cmd_took = cmd_valid && !cmd_stall;
			rsp_took = rsp_valid && !rsp_stall;
			if (cmd_took)
				answers_due.push_back(table_apply(command, value));
			if (rsp_took) begin
				rsp_count++;
				if (answers_due.size() == 0) begin
					log_mismatch($sformatf("unexpected result beat: status %0d count %0d",
						status, entry_count));
				end else begin
					want = answers_due.pop_front();
					if (status !== want.status || entry_count !== want.entry_count)
						log_mismatch($sformatf(
							"op %0d value %0d: expected status %0d count %0d, got %0d %0d",
							want.op, want.operand, want.status, want.entry_count,
							status, entry_count));
				end
			end
			// watchdog: count cycles where nothing moves on either side
			if (cmd_took || rsp_took)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT)
				timed_out = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Driver: change the command channel at the falling edge. Hold a beat
	// until it is taken, then wait its drawn gap before offering the next.
	// ------------------------------------------------------------------
	int cmd_gap = 0;
	int cmd_burst = 0;

	always @(negedge clk) begin
		table_cmd_t c;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!(cmd_valid && !cmd_took)) begin
			if (cmd_gap > 0) begin
				cmd_valid <= 1'b0;
				cmd_gap--;
			end else if (pending.size() > 0) begin
				c = pending.pop_front();
				command   <= c.op;
				value     <= c.operand;
				cmd_valid <= 1'b1;
				cmd_gap   = draw_wait(cmd_burst);
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall for a drawn number of cycles after each result beat;
	// the long hold-off below overrides it.
	// ------------------------------------------------------------------
	int  rsp_wait = 0;
	int  rsp_burst = 0;
	bit  hold_results = 1'b0;

	always @(negedge clk) begin
		if (rsp_took)
			rsp_wait = draw_wait(rsp_burst);
		if (hold_results) begin
			rsp_stall <= 1'b1;
		end else if (rsp_wait > 0) begin
			rsp_stall <= 1'b1;
			rsp_wait--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Block the result channel for a long stretch mid-run while the sender
	// keeps offering, so the result register and engine back up into the
	// command channel.
	initial begin
		wait (rsp_count >= 300);
		@(posedge clk);
		hold_results = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_results = 1'b0;
	end

	// ------------------------------------------------------------------
	// Main sequence: build stimulus, reset, wait for every answer, report.
	// ------------------------------------------------------------------
	initial begin
		int         made;
		int         phase;
		int         span;
		int         r;
		logic [1:0] op;

		// directed: empty-table corners first
		queue_op(slt_pkg::CMD_SEARCH, 0);
		queue_op(slt_pkg::CMD_DELETE, 5);
		queue_op(slt_pkg::CMD_CLEAR, 32'sh1234_5678);
		// extremes of the value range, duplicates at head, middle and tail
		queue_op(slt_pkg::CMD_INSERT, 0);
		queue_op(slt_pkg::CMD_INSERT, 32'sh7fff_ffff);
		queue_op(slt_pkg::CMD_INSERT, 32'sh8000_0000);
		queue_op(slt_pkg::CMD_INSERT, -1);
		queue_op(slt_pkg::CMD_INSERT, 1);
		queue_op(slt_pkg::CMD_INSERT, 0);
		queue_op(slt_pkg::CMD_INSERT, 32'sh8000_0000);
		queue_op(slt_pkg::CMD_INSERT, 32'sh7fff_ffff);
		queue_op(slt_pkg::CMD_SEARCH, 32'sh8000_0000);
		queue_op(slt_pkg::CMD_SEARCH, 32'sh7fff_ffff);
		queue_op(slt_pkg::CMD_SEARCH, 7);
		queue_op(slt_pkg::CMD_SEARCH, 32'sh7fff_fffe);
		// delete the first of a duplicate pair, then check the other remains
		queue_op(slt_pkg::CMD_DELETE, 0);
		queue_op(slt_pkg::CMD_SEARCH, 0);
		queue_op(slt_pkg::CMD_DELETE, 32'sh7fff_ffff);
		queue_op(slt_pkg::CMD_DELETE, 32'sh8000_0000);
		queue_op(slt_pkg::CMD_DELETE, 12345);
		queue_op(slt_pkg::CMD_CLEAR, 0);
		// toggle every operand bit after a clear, reusing freed nodes
		queue_op(slt_pkg::CMD_INSERT, 32'sh5555_5555);
		queue_op(slt_pkg::CMD_INSERT, 32'shaaaa_aaaa);
		queue_op(slt_pkg::CMD_DELETE, 32'sh5555_5555);

		// random: phases that fill the store to full, drain it, mix and scramble
		made = 0;
		while (made < RANDOM_ITEMS) begin
			phase = $urandom_range(0, 99);
			span  = $urandom_range(60, 180);
			for (int k = 0; k < span && made < RANDOM_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (phase < 30)
					op = (r < 85) ? slt_pkg::CMD_INSERT :
						(r < 92) ? slt_pkg::CMD_SEARCH : slt_pkg::CMD_DELETE;
				else if (phase < 55)
					op = (r < 75) ? slt_pkg::CMD_DELETE :
						(r < 90) ? slt_pkg::CMD_SEARCH : slt_pkg::CMD_INSERT;
				else if (phase < 90)
					op = (r < 40) ? slt_pkg::CMD_INSERT : (r < 68) ? slt_pkg::CMD_DELETE :
						(r < 96) ? slt_pkg::CMD_SEARCH : slt_pkg::CMD_CLEAR;
				else
					op = 2'($urandom_range(0, 3));
				queue_op(op, pick_operand());
				made++;
			end
			if ($urandom_range(0, 3) == 0) begin
				queue_op(slt_pkg::CMD_CLEAR, $urandom);
				made++;
			end
		end
		total_items = pending.size();

		// reset once, released away from the rising edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (rsp_count < total_items && !timed_out)
			@(negedge clk);

		if (timed_out) begin
			$display("watchdog: no beat for %0d cycles, %0d of %0d results seen",
				QUIET_LIMIT, rsp_count, total_items);
			$display("sorted_linked_list_table_core verification failed");
		end else begin
			// let any stray extra beat show up before judging
			repeat (SETTLE_CYCLES) @(negedge clk);
			if (answers_due.size() > 0)
				log_mismatch($sformatf("%0d answers never arrived", answers_due.size()));
			$display("Ran %0d commands: %0d inserts (%0d refused on a full store),",
				total_items, n_insert, n_refused);
			$display("  %0d deletes, %0d searches, %0d clears, %0d not-found answers,",
				n_delete, n_search, n_clear, n_absent);
			$display("  list depth up to %0d entries, %0d mismatches", deepest, mismatches);
			if (mismatches == 0)
				$display("sorted_linked_list_table_core verification clean");
			else
				$display("sorted_linked_list_table_core verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/slt_pkg.sv
design/slt_ram.sv
design/slt_engine.sv
design/sorted_linked_list_table_core.sv
verif/sorted_linked_list_table_core_tb.sv
